/* design/scatter_gather_copy_splitter_unit_assert.svh */
// assertion macros for the copy splitter modules
// no dependencies; included by sgcs_back, the module that carries checks
`ifndef SCATTER_GATHER_COPY_SPLITTER_UNIT_ASSERT_SVH
`define SCATTER_GATHER_COPY_SPLITTER_UNIT_ASSERT_SVH

// same-cycle implication, checked outside reset
`define SGCS_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("sgcs check failed");

// next-cycle implication, checked outside reset
`define SGCS_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("sgcs check failed");

`endif

/* design/sgcs_pkg.sv */
// shared types and constants of the scatter-gather copy splitter
// no dependencies
`default_nettype none

package sgcs_pkg;

    typedef enum logic [1:0] {
        OP_SRC   = 2'd0,
        OP_DST   = 2'd1,
        OP_FAULT = 2'd2
    } t_op_e;

    typedef enum logic [1:0] {
        NEED_SRC  = 2'd0,
        NEED_DST  = 2'd1,
        NEED_BOTH = 2'd2
    } t_need_e;

    typedef enum logic [1:0] {
        ST_OK     = 2'd0,
        ST_FAULT  = 2'd1,
        ST_OFFSET = 2'd2
    } t_status_e;

    // descriptor queue between front and back, depth is a power of two
    localparam int QUEUE_DEPTH    = 4;
    localparam int QUEUE_PTR_BITS = $clog2(QUEUE_DEPTH);
    localparam int QUEUE_CNT_BITS = $clog2(QUEUE_DEPTH + 1);

    typedef struct packed {
        logic [1:0]  operation;
        logic [31:0] base_address;
        logic [31:0] segment_length;
        logic [31:0] start_offset;
        logic        first_segment;
        logic        last_segment;
    } t_in_item;

    typedef struct packed {
        logic        command_valid;
        logic [31:0] copy_dest;
        logic [31:0] copy_source;
        logic [31:0] copy_length;
        t_need_e     need_side;
        logic        transfer_done;
        t_status_e   status;
        logic [31:0] bytes_total;
    } t_out_item;

    // classified descriptor, cursor travels beside it
    typedef struct packed {
        logic [1:0]  operation;
        logic [31:0] remaining;
        logic        bad_offset;
        logic        is_last;
    } t_desc_info;

endpackage

`default_nettype wire

/* design/sgcs_if.sv */
// valid/ready channel interfaces for descriptor input and result output
// depends on sgcs_pkg
`default_nettype none

interface sgcs_in_if;
    import sgcs_pkg::*;
    logic     valid;
    logic     ready;
    t_in_item payload;
    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

interface sgcs_out_if;
    import sgcs_pkg::*;
    logic      valid;
    logic      ready;
    t_out_item payload;
    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

`default_nettype wire

/* design/sgcs_front.sv */
// front classifier: applies start offset, flags bad offsets
// depends on sgcs_pkg
`default_nettype none

module sgcs_front #(
    parameter int ADDR_BITS = 32
) (
    input  sgcs_pkg::t_in_item   i_item,
    output sgcs_pkg::t_desc_info o_info,
    output logic [ADDR_BITS-1:0] o_cursor
);
    import sgcs_pkg::*;

    localparam int SUM_BITS = (ADDR_BITS > 32) ? ADDR_BITS : 32;

    logic [31:0]         off_eff;
    logic [SUM_BITS-1:0] addr_sum;

    // offset applies only on the first descriptor of a side
    assign off_eff  = i_item.first_segment ? i_item.start_offset : 32'd0;
    assign addr_sum = SUM_BITS'(i_item.base_address) + SUM_BITS'(off_eff);

    assign o_cursor            = addr_sum[ADDR_BITS-1:0];
    assign o_info.operation    = i_item.operation;
    assign o_info.remaining    = i_item.segment_length - off_eff;
    assign o_info.bad_offset   = i_item.first_segment &&
                                 (i_item.start_offset > i_item.segment_length);
    assign o_info.is_last      = i_item.last_segment;

endmodule

`default_nettype wire

/* design/sgcs_queue.sv */
// short fifo of classified descriptors between front and back
// depends on sgcs_pkg for depth constants
`default_nettype none

module sgcs_queue #(
    parameter int WIDTH = 36
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    output logic             o_full,
    output logic             o_valid,
    input  logic             i_pop,
    output logic [WIDTH-1:0] o_data
);
    import sgcs_pkg::*;

    logic [WIDTH-1:0]          r_slots [QUEUE_DEPTH];
    logic [QUEUE_PTR_BITS-1:0] r_wr_ptr;
    logic [QUEUE_PTR_BITS-1:0] r_rd_ptr;
    logic [QUEUE_CNT_BITS-1:0] r_count;

    assign o_full  = (r_count == QUEUE_CNT_BITS'(QUEUE_DEPTH));
    assign o_valid = (r_count != '0);
    assign o_data  = r_slots[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_slots[r_wr_ptr] <= i_data;
        end
    end

    // pointers wrap naturally at a power-of-two depth
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            unique case ({i_push, i_pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

`default_nettype wire

/* design/sgcs_back.sv */
// back end: holds one descriptor per side, merges them into copy commands
// depends on sgcs_pkg, sgcs_if and the assertion macro header
`default_nettype none
`include "scatter_gather_copy_splitter_unit_assert.svh"

module sgcs_back #(
    parameter int ADDR_BITS = 32
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    input  sgcs_pkg::t_desc_info i_info,
    input  logic [ADDR_BITS-1:0] i_cursor,
    output logic                 o_pop,
    sgcs_out_if.source           o_out
);
    import sgcs_pkg::*;

    logic [ADDR_BITS-1:0] r_src_cursor, n_src_cursor;
    logic [31:0]          r_src_remaining, n_src_remaining;
    logic                 r_src_present, n_src_present;
    logic                 r_src_is_last, n_src_is_last;
    logic [ADDR_BITS-1:0] r_dst_cursor, n_dst_cursor;
    logic [31:0]          r_dst_remaining, n_dst_remaining;
    logic                 r_dst_present, n_dst_present;
    logic                 r_dst_is_last, n_dst_is_last;
    logic [31:0]          r_bytes_moved, n_bytes_moved;
    logic                 r_finished, n_finished;
    logic                 r_out_valid;
    t_out_item            r_out;
    t_out_item            n_out;

    // take from the queue whenever the output register is free or draining
    assign o_pop = i_valid && (!r_out_valid || o_out.ready);

    always_comb begin
        logic [ADDR_BITS-1:0] cmd_dst;
        logic [ADDR_BITS-1:0] cmd_src;
        logic [31:0]          cmd_len;
        logic                 cmd_valid;
        t_status_e            status;

        n_src_cursor    = r_src_cursor;
        n_src_remaining = r_src_remaining;
        n_src_present   = r_src_present;
        n_src_is_last   = r_src_is_last;
        n_dst_cursor    = r_dst_cursor;
        n_dst_remaining = r_dst_remaining;
        n_dst_present   = r_dst_present;
        n_dst_is_last   = r_dst_is_last;
        n_bytes_moved   = r_bytes_moved;
        n_finished      = r_finished;
        cmd_dst         = '0;
        cmd_src         = '0;
        cmd_len         = '0;
        cmd_valid       = 1'b0;
        status          = ST_OK;

        if (!r_finished) begin
            unique case (i_info.operation)
                OP_SRC, OP_DST: begin
                    if (i_info.bad_offset) begin
                        n_finished = 1'b1;
                        status     = ST_OFFSET;
                    end else begin
                        // a new descriptor replaces any held one of its side
                        if (i_info.operation == OP_DST) begin
                            n_dst_cursor    = i_cursor;
                            n_dst_remaining = i_info.remaining;
                            n_dst_present   = 1'b1;
                            n_dst_is_last   = i_info.is_last;
                        end else begin
                            n_src_cursor    = i_cursor;
                            n_src_remaining = i_info.remaining;
                            n_src_present   = 1'b1;
                            n_src_is_last   = i_info.is_last;
                        end
                        if (n_src_present && n_dst_present) begin
                            cmd_valid = 1'b1;
                            cmd_dst   = n_dst_cursor;
                            cmd_src   = n_src_cursor;
                            if (n_src_remaining < n_dst_remaining) begin
                                cmd_len         = n_src_remaining;
                                n_src_present   = 1'b0;
                                n_finished      = n_src_is_last;
                                n_dst_cursor    = n_dst_cursor + ADDR_BITS'(n_src_remaining);
                                n_dst_remaining = n_dst_remaining - n_src_remaining;
                            end else if (n_dst_remaining < n_src_remaining) begin
                                cmd_len         = n_dst_remaining;
                                n_dst_present   = 1'b0;
                                n_finished      = n_dst_is_last;
                                n_src_cursor    = n_src_cursor + ADDR_BITS'(n_dst_remaining);
                                n_src_remaining = n_src_remaining - n_dst_remaining;
                            end else begin
                                cmd_len         = n_src_remaining;
                                n_src_present   = 1'b0;
                                n_dst_present   = 1'b0;
                                n_finished      = n_src_is_last || n_dst_is_last;
                                n_src_remaining = '0;
                                n_dst_remaining = '0;
                            end
                            n_bytes_moved = r_bytes_moved + cmd_len;
                        end
                    end
                end
                OP_FAULT: begin
                    n_finished = 1'b1;
                    status     = ST_FAULT;
                end
                default: begin
                end
            endcase
        end

        n_out.command_valid = cmd_valid;
        n_out.copy_dest     = 32'(cmd_dst);
        n_out.copy_source   = 32'(cmd_src);
        n_out.copy_length   = cmd_len;
        n_out.transfer_done = n_finished;
        n_out.status        = status;
        n_out.bytes_total   = n_bytes_moved;
        if (n_finished) begin
            n_out.need_side = NEED_SRC;
        end else if (!n_src_present && !n_dst_present) begin
            n_out.need_side = NEED_BOTH;
        end else if (!n_src_present) begin
            n_out.need_side = NEED_SRC;
        end else begin
            n_out.need_side = NEED_DST;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_src_cursor    <= '0;
            r_src_remaining <= '0;
            r_src_present   <= 1'b0;
            r_src_is_last   <= 1'b0;
            r_dst_cursor    <= '0;
            r_dst_remaining <= '0;
            r_dst_present   <= 1'b0;
            r_dst_is_last   <= 1'b0;
            r_bytes_moved   <= '0;
            r_finished      <= 1'b0;
            r_out_valid     <= 1'b0;
        end else begin
            if (o_pop) begin
                r_src_cursor    <= n_src_cursor;
                r_src_remaining <= n_src_remaining;
                r_src_present   <= n_src_present;
                r_src_is_last   <= n_src_is_last;
                r_dst_cursor    <= n_dst_cursor;
                r_dst_remaining <= n_dst_remaining;
                r_dst_present   <= n_dst_present;
                r_dst_is_last   <= n_dst_is_last;
                r_bytes_moved   <= n_bytes_moved;
                r_finished      <= n_finished;
                r_out_valid     <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_out <= n_out;
        end
    end

    assign o_out.valid   = r_out_valid;
    assign o_out.payload = r_out;

    `SGCS_ASSERT_NXT(a_finished_sticks, i_clk, i_rst_n, r_finished, r_finished)
    `SGCS_ASSERT_IMP(a_status_ends, i_clk, i_rst_n, r_out_valid && (r_out.status != ST_OK), r_out.transfer_done)
    `SGCS_ASSERT_NXT(a_no_cmd_after_end, i_clk, i_rst_n, o_pop && r_finished, !r_out.command_valid && r_out.transfer_done)

endmodule

`default_nettype wire

/* design/scatter_gather_copy_splitter_unit.sv */
// an accepted descriptor is written to the queue, then merged into the output register
// throughput: one descriptor per cycle while the output register is free or draining,
// set by the back end merge step; a four-entry queue decouples the descriptor side
// from result stalls; reset (synchronous, active low) empties the queue, drops held
// descriptors, clears the byte count and the done flag; no result is pending after reset
`default_nettype none

module scatter_gather_copy_splitter_unit #(
    parameter int ADDR_BITS = 32
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    sgcs_in_if.sink    i_in,
    sgcs_out_if.source o_out
);
    import sgcs_pkg::*;

    localparam int ENTRY_BITS = $bits(t_desc_info) + ADDR_BITS;

    // front side: classify descriptor, apply start offset
    t_desc_info           front_info;
    logic [ADDR_BITS-1:0] front_cursor;

    // queue between front and back
    logic                  q_push;
    logic                  q_full;
    logic                  q_valid;
    logic                  q_pop;
    logic [ENTRY_BITS-1:0] q_head;

    // back side view of the head entry
    t_desc_info           head_info;
    logic [ADDR_BITS-1:0] head_cursor;

    sgcs_front #(
        .ADDR_BITS (ADDR_BITS)
    ) u_front (
        .i_item   (i_in.payload),
        .o_info   (front_info),
        .o_cursor (front_cursor)
    );

    // accept whenever the queue has room; the back drains it independently
    assign i_in.ready = !q_full;
    assign q_push     = i_in.valid && !q_full;

    sgcs_queue #(
        .WIDTH (ENTRY_BITS)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_data  ({front_info, front_cursor}),
        .o_full  (q_full),
        .o_valid (q_valid),
        .i_pop   (q_pop),
        .o_data  (q_head)
    );

    assign head_info   = t_desc_info'(q_head[ENTRY_BITS-1:ADDR_BITS]);
    assign head_cursor = q_head[ADDR_BITS-1:0];

    // back side: per-side descriptor state, command merge, output register
    sgcs_back #(
        .ADDR_BITS (ADDR_BITS)
    ) u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (q_valid),
        .i_info   (head_info),
        .i_cursor (head_cursor),
        .o_pop    (q_pop),
        .o_out    (o_out)
    );

endmodule

`default_nettype wire

/* test/copy_command_checker.sv */
// checker for the scatter-gather copy splitter: watches both channels and predicts each result
// depends on sgcs_pkg and the channel interfaces in sgcs_if
`default_nettype none

module copy_command_checker #(
    parameter int ADDR_BITS = 32
) (
    input  logic i_clk,
    input  logic i_rst_n,
    sgcs_in_if   i_desc,
    sgcs_out_if  i_result,
    output int   o_fail_count,
    output int   o_pending,
    output int   o_command_count
);
    import sgcs_pkg::*;

    // shifting by 64 gives zero, so the minus one also covers the full width
    localparam logic [63:0] ADDR_MASK = (64'd1 << ADDR_BITS) - 64'd1;

    logic [63:0] src_cur, dst_cur;
    logic [31:0] src_left, dst_left, byte_count;
    logic        src_held, src_last, dst_held, dst_last, done_flag;

    t_out_item   expected_cmds[$];
    t_out_item   want, got;
    int          fail_total;
    int          command_total;

    function automatic t_out_item merge_step(t_in_item d);
        t_out_item   r;
        logic [63:0] base;
        logic [31:0] len_left;
        logic [31:0] n;
        r = '0;
        r.need_side = NEED_SRC;
        r.status = ST_OK;
        if (!done_flag) begin
            if (d.operation == OP_SRC || d.operation == OP_DST) begin
                base = {32'd0, d.base_address};
                len_left = d.segment_length;
                if (d.first_segment && d.start_offset > d.segment_length) begin
                    done_flag = 1'b1;
                    r.status = ST_OFFSET;
                end else begin
                    if (d.first_segment) begin
                        base = base + {32'd0, d.start_offset};
                        len_left = d.segment_length - d.start_offset;
                    end
                    base = base & ADDR_MASK;
                    if (d.operation == OP_DST) begin
                        dst_cur = base;
                        dst_left = len_left;
                        dst_held = 1'b1;
                        dst_last = d.last_segment;
                    end else begin
                        src_cur = base;
                        src_left = len_left;
                        src_held = 1'b1;
                        src_last = d.last_segment;
                    end
                    if (src_held && dst_held) begin
                        r.command_valid = 1'b1;
                        r.copy_dest = dst_cur[31:0];
                        r.copy_source = src_cur[31:0];
                        if (src_left < dst_left) begin
                            n = src_left;
                            src_held = 1'b0;
                            if (src_last) done_flag = 1'b1;
                            dst_cur = (dst_cur + {32'd0, n}) & ADDR_MASK;
                            dst_left = dst_left - n;
                        end else if (dst_left < src_left) begin
                            n = dst_left;
                            dst_held = 1'b0;
                            if (dst_last) done_flag = 1'b1;
                            src_cur = (src_cur + {32'd0, n}) & ADDR_MASK;
                            src_left = src_left - n;
                        end else begin
                            n = src_left;
                            src_held = 1'b0;
                            dst_held = 1'b0;
                            if (src_last || dst_last) done_flag = 1'b1;
                            src_left = '0;
                            dst_left = '0;
                        end
                        r.copy_length = n;
                        byte_count = byte_count + n;
                    end
                end
            end else if (d.operation == OP_FAULT) begin
                done_flag = 1'b1;
                r.status = ST_FAULT;
            end
        end
        if (!done_flag) begin
            if (!src_held && !dst_held) r.need_side = NEED_BOTH;
            else if (!src_held) r.need_side = NEED_SRC;
            else r.need_side = NEED_DST;
        end
        r.transfer_done = done_flag;
        r.bytes_total = byte_count;
        return r;
    endfunction

    task automatic check_field(string field, logic [31:0] exp_val, logic [31:0] act_val);
        if (act_val !== exp_val) begin
            $error("%s mismatch: expected %0h, actual %0h", field, exp_val, act_val);
            fail_total++;
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            src_cur = '0;
            src_left = '0;
            src_held = 1'b0;
            src_last = 1'b0;
            dst_cur = '0;
            dst_left = '0;
            dst_held = 1'b0;
            dst_last = 1'b0;
            byte_count = '0;
            done_flag = 1'b0;
            expected_cmds.delete();
            fail_total = 0;
            command_total = 0;
        end else begin
            if (i_desc.valid && i_desc.ready) expected_cmds.push_back(merge_step(i_desc.payload));
            if (i_result.valid && i_result.ready) begin
                if (expected_cmds.size() == 0) begin
                    $error("result transfer with no expectation waiting");
                    fail_total++;
                end else begin
                    want = expected_cmds.pop_front();
                    got = i_result.payload;
                    check_field("command_valid", 32'(want.command_valid), 32'(got.command_valid));
                    check_field("copy_dest", want.copy_dest, got.copy_dest);
                    check_field("copy_source", want.copy_source, got.copy_source);
                    check_field("copy_length", want.copy_length, got.copy_length);
                    check_field("need_side", 32'(want.need_side), 32'(got.need_side));
                    check_field("transfer_done", 32'(want.transfer_done), 32'(got.transfer_done));
                    check_field("status", 32'(want.status), 32'(got.status));
                    check_field("bytes_total", want.bytes_total, got.bytes_total);
                    if (got.command_valid === 1'b1) command_total++;
                end
            end
        end
        o_fail_count <= fail_total;
        o_pending <= expected_cmds.size();
        o_command_count <= command_total;
    end

endmodule

`default_nettype wire

/* test/tb_top.sv */
// top of the copy splitter testbench: clock, reset, descriptor stimulus and verdict
// depends on sgcs_pkg, sgcs_if, copy_command_checker and the splitter itself
`default_nettype none

module tb_top;
    import sgcs_pkg::*;

    localparam int          ADDR_BITS    = 32;
    localparam int          DESC_TARGET  = 1620;   // directed plus random descriptors
    localparam int          CALM_AFTER   = 1420;   // no idling on either side past this
    localparam int unsigned CYCLE_LIMIT  = 400000;
    localparam logic [1:0]  OP_UNUSED    = 2'd3;

    typedef enum {END_FAULT, END_OFFSET, END_LAST} t_end_e;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;

    // channel drivers, known from time zero
    logic        desc_valid = 1'b0;
    t_in_item    desc_item = '0;
    logic        result_ready = 1'b0;

    sgcs_in_if   desc_ch();
    sgcs_out_if  result_ch();

    assign desc_ch.valid   = desc_valid;
    assign desc_ch.payload = desc_item;
    assign result_ch.ready = result_ready;

    int          fail_count;
    int          pending;
    int          command_count;

    int unsigned cycle_count = 0;
    logic        quiet = 1'b0;       // stretch with no idling at all
    logic        calm = 1'b0;        // final part of the run, no idling
    int          stall_left = 0;

    // stimulus-side view of what the block holds, just enough to steer
    // the random part away from ending the transfer early
    bit          held_q[2];
    bit          last_q[2];
    logic [31:0] left_q[2];
    bit          gen_ended;
    bit          closing;

    int          desc_count;
    int          noise_count;
    t_end_e      end_kind;

    scatter_gather_copy_splitter_unit #(
        .ADDR_BITS (ADDR_BITS)
    ) dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (desc_ch),
        .o_out   (result_ch)
    );

    copy_command_checker #(
        .ADDR_BITS (ADDR_BITS)
    ) u_checker (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_desc          (desc_ch),
        .i_result        (result_ch),
        .o_fail_count    (fail_count),
        .o_pending       (pending),
        .o_command_count (command_count)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // cycle budget, and a new pick of quiet or bursty whenever the low eight bits of the cycle count are zero
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count[7:0] == 8'd0) quiet <= ($urandom_range(0, 3) == 0);
        if (cycle_count > CYCLE_LIMIT) begin
            $display("FAIL scatter_gather_copy_splitter_unit");
            $finish;
        end
    end

    // result side: ready drops now and then for a randomly drawn stretch, counted down in stall_left
    always @(posedge i_clk) begin
        if (stall_left != 0) begin
            stall_left <= stall_left - 1;
            result_ready <= (stall_left == 1);
        end else if (!calm && !quiet && $urandom_range(0, 5) == 0) begin
            stall_left <= $urandom_range(13, 1);
            result_ready <= 1'b0;
        end else begin
            result_ready <= 1'b1;
        end
    end

    // apply one descriptor to the stimulus-side view
    function automatic void track(t_in_item d);
        logic [31:0] r;
        int          s;
        int          o;
        if (gen_ended) return;
        if (d.operation == OP_FAULT) begin
            gen_ended = 1'b1;
            return;
        end
        if (d.operation != OP_SRC && d.operation != OP_DST) return;
        if (d.first_segment && d.start_offset > d.segment_length) begin
            gen_ended = 1'b1;
            return;
        end
        s = int'(d.operation[0]);
        o = 1 - s;
        r = d.first_segment ? d.segment_length - d.start_offset : d.segment_length;
        held_q[s] = 1'b1;
        left_q[s] = r;
        last_q[s] = d.last_segment;
        if (held_q[o]) begin
            if (left_q[s] < left_q[o]) begin
                held_q[s] = 1'b0;
                left_q[o] = left_q[o] - left_q[s];
                gen_ended = last_q[s];
            end else if (left_q[o] < left_q[s]) begin
                held_q[o] = 1'b0;
                left_q[s] = left_q[s] - left_q[o];
                gen_ended = last_q[o];
            end else begin
                held_q[0] = 1'b0;
                held_q[1] = 1'b0;
                gen_ended = last_q[0] || last_q[1];
            end
        end
    endfunction

    function automatic bit would_end(t_in_item d);
        bit          held_keep[2];
        bit          last_keep[2];
        logic [31:0] left_keep[2];
        bit          ended_keep;
        bit          verdict;
        held_keep = held_q;
        last_keep = last_q;
        left_keep = left_q;
        ended_keep = gen_ended;
        track(d);
        verdict = gen_ended;
        held_q = held_keep;
        last_q = last_keep;
        left_q = left_keep;
        gen_ended = ended_keep;
        return verdict;
    endfunction

    // before the closing part nothing may end the transfer: repair the offset,
    // then drop the last flag, and as a last resort replace the other side's
    // held last descriptor instead (our side cannot be held then)
    function automatic void make_safe(inout t_in_item d);
        if (d.operation == OP_FAULT) d.operation = OP_UNUSED;
        if (would_end(d) && d.first_segment && d.start_offset > d.segment_length)
            d.start_offset = $urandom_range(d.segment_length, 0);
        if (would_end(d)) d.last_segment = 1'b0;
        if (would_end(d)) begin
            d.operation = (d.operation == OP_SRC) ? OP_DST : OP_SRC;
            d.last_segment = 1'b0;
        end
    endfunction

    function automatic t_in_item make_desc(logic [1:0] op, logic [31:0] base, logic [31:0] len,
                                           logic [31:0] off, logic first, logic last);
        t_in_item d;
        d.operation = op;
        d.base_address = base;
        d.segment_length = len;
        d.start_offset = off;
        d.first_segment = first;
        d.last_segment = last;
        return d;
    endfunction

    function automatic t_in_item random_desc();
        t_in_item d;
        int       o;
        int       pick;
        d.operation = $urandom_range(0, 1) ? OP_DST : OP_SRC;
        if ($urandom_range(0, 31) == 0) d.operation = OP_UNUSED;
        o = 1 - d.operation[0];
        d.base_address = ($urandom_range(0, 4) == 0) ? 32'hFFFF_FFFF - $urandom_range(255, 0)
                                                     : $urandom();
        d.first_segment = ($urandom_range(0, 3) == 0);
        d.last_segment = ($urandom_range(0, 4) == 0);
        pick = $urandom_range(0, 99);
        if (pick < 6) d.segment_length = '0;
        else if (pick < 45) d.segment_length = $urandom_range(64, 1);
        else if (pick < 60 && held_q[o]) begin
            // same remaining length as the other side, both retire together
            d.segment_length = left_q[o];
            d.first_segment = 1'b0;
        end else if (pick < 70) d.segment_length = $urandom_range(4096, 65);
        else d.segment_length = $urandom();
        pick = $urandom_range(0, 9);
        if (!d.first_segment) d.start_offset = $urandom();
        else if (pick == 0) d.start_offset = d.segment_length;
        else if (pick == 1) d.start_offset = $urandom();   // often too big, repaired later
        else d.start_offset = $urandom_range(d.segment_length, 0);
        return d;
    endfunction

    // one transfer on the descriptor channel, with an optional idle burst first
    task automatic drive(t_in_item d);
        if (!calm && !quiet && $urandom_range(0, 4) == 0) begin
            desc_valid <= 1'b0;
            repeat ($urandom_range(13, 1)) @(posedge i_clk);
        end
        desc_valid <= 1'b1;
        desc_item <= d;
        @(posedge i_clk);
        while (!desc_ch.ready) @(posedge i_clk);
    endtask

    task automatic issue(t_in_item d);
        if (!closing) make_safe(d);
        track(d);
        if (d.operation == OP_SRC || d.operation == OP_DST) desc_count++;
        else noise_count++;
        drive(d);
    endtask

    initial begin
        logic [31:0] len;
        logic [1:0]  side;
        held_q = '{2{1'b0}};
        last_q = '{2{1'b0}};
        left_q = '{2{32'd0}};
        gen_ended = 1'b0;
        closing = 1'b0;
        desc_count = 0;
        noise_count = 0;

        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: field extremes, offset equal to length, zero lengths,
        // equal lengths, replacement of a held descriptor, unused code,
        // cursor and byte count wrap
        issue(make_desc(OP_UNUSED, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, 1'b1));
        issue(make_desc(OP_SRC, 32'h0, 32'h0, 32'h0, 1'b1, 1'b0));
        issue(make_desc(OP_DST, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h0, 1'b1, 1'b1));
        issue(make_desc(OP_SRC, 32'hFFFF_FFFF, 32'd10, 32'h0, 1'b0, 1'b0));
        issue(make_desc(OP_DST, 32'h1000, 32'd100, 32'd100, 1'b1, 1'b0));
        issue(make_desc(OP_SRC, 32'h2000, 32'h0, 32'h0, 1'b0, 1'b0));
        issue(make_desc(OP_SRC, 32'h5000, 32'd300, 32'h0, 1'b1, 1'b1));
        issue(make_desc(OP_SRC, 32'h6000, 32'd50, 32'd20, 1'b1, 1'b0));
        issue(make_desc(OP_DST, 32'h7000, 32'd30, 32'h0, 1'b0, 1'b0));
        issue(make_desc(OP_DST, 32'hFFFF_FF00, 32'h200, 32'h0, 1'b0, 1'b0));
        issue(make_desc(OP_SRC, 32'h8000_0000, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, 1'b0));
        issue(make_desc(OP_UNUSED, 32'h0, 32'h0, 32'h0, 1'b0, 1'b0));
        issue(make_desc(OP_SRC, 32'hAAAA_AAAA, 32'h100, 32'h0, 1'b0, 1'b0));
        issue(make_desc(OP_SRC, 32'h5555_5555, 32'h300, 32'h0, 1'b0, 1'b0));
        issue(make_desc(OP_DST, 32'h1234_5678, 32'h200, 32'h0, 1'b1, 1'b0));
        issue(make_desc(OP_DST, 32'h0, 32'hFFFF_FFFF, 32'h0, 1'b0, 1'b0));
        issue(make_desc(OP_SRC, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'd1, 1'b1, 1'b0));
        issue(make_desc(OP_SRC, 32'h100, 32'h1000, 32'h0, 1'b0, 1'b1));
        issue(make_desc(OP_DST, 32'h200, 32'h800, 32'h0, 1'b0, 1'b0));
        issue(make_desc(OP_SRC, 32'h300, 32'd5, 32'h0, 1'b0, 1'b0));
        issue(make_desc(OP_DST, 32'h400, 32'd5, 32'h0, 1'b1, 1'b0));

        // random descriptors, all within one long transfer
        while (desc_count < DESC_TARGET) begin
            if (!calm && desc_count >= CALM_AFTER) calm <= 1'b1;
            issue(random_desc());
        end

        // closing: end the transfer one of three ways, then a few items it must ignore
        closing = 1'b1;
        end_kind = t_end_e'($urandom_range(0, 2));
        side = $urandom_range(0, 1) ? OP_DST : OP_SRC;
        case (end_kind)
            END_FAULT: begin
                issue(make_desc(OP_FAULT, $urandom(), $urandom(), $urandom(), 1'b0, 1'b0));
            end
            END_OFFSET: begin
                len = $urandom_range(32'hFFFF_FFFE, 0);
                issue(make_desc(side, $urandom(), len, $urandom_range(32'hFFFF_FFFF, len + 1),
                                1'b1, 1'($urandom_range(0, 1))));
            end
            default: begin
                // a zero-length last descriptor always runs out first or together
                issue(make_desc(side, $urandom(), 32'h0, $urandom(), 1'b0, 1'b1));
                issue(make_desc(side ^ 2'd1, $urandom(), $urandom(), $urandom(), 1'b0,
                                1'($urandom_range(0, 1))));
            end
        endcase
        repeat (6) begin
            issue(make_desc(2'($urandom_range(0, 3)), $urandom(), $urandom(), $urandom(),
                            1'($urandom_range(0, 1)), 1'($urandom_range(0, 1))));
        end
        desc_valid <= 1'b0;

        // drain, then keep watching for anything stray
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);

        $display("run covered %0d descriptors and %0d other items in one transfer, ended by %s",
                 desc_count, noise_count, end_kind.name());
        $display("%0d copy commands checked, %0d cycles", command_count, cycle_count);
        if (fail_count == 0) begin
            $display("PASS scatter_gather_copy_splitter_unit");
        end else begin
            $display("FAIL scatter_gather_copy_splitter_unit");
        end
        $finish;
    end

endmodule

`default_nettype wire
